/* src/drp_pkg.sv */
// Shared types and constants for the delimited record parser.
// No dependencies; imported by the top level and by drp_num.
`default_nettype none

package drp_pkg;

    // Fixed field widths
    localparam int STAMP_W = 55;
    localparam int KEY_W   = 21;
    localparam int LEN_W   = 7;
    localparam int WORD_W  = 64;
    localparam int LIMIT_W = 7;

    // Character codes
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    // Control from the byte router to a number field parser
    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] ch;
    } num_ctl_t;

endpackage

`default_nettype wire

/* src/delimited_record_parser_top.sv */
// Top level of the delimited record parser: byte routing, value buffer, drain.
// Depends on drp_pkg, drp_ram and drp_num.
`default_nettype none

// Takes text one byte per transfer, records timestamp;key;value ended by a newline.
// Timestamp and key parse as decimal (atoi rules), value bytes are stored in a
// word RAM of ceil(MAX_VALUE/8) 64-bit entries, packed as they arrive. A byte is
// taken every cycle while a record is being parsed. On the newline byte the input
// stalls while the record drains: the header, then each full value word, read from
// the RAM (registered read) and presented, then any partial final word, all under
// output backpressure. tlast on the input drops an unterminated record. The user
// must write value_limit only while idle; the block itself does not enforce it.
module delimited_record_parser_top
    import drp_pkg::*;
#(
    parameter int MAX_VALUE   = 64,
    parameter int KEY_CHARS   = 6,
    parameter int STAMP_CHARS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Configuration
    input  wire logic           value_limit_wr,
    input  wire logic [6:0]     value_limit_data,
    // Byte input
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,   // [7:0] char_in
    input  wire logic           s_axis_tlast,   // end_of_item
    // Result output
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // [54:0] stamp, [75:55] record_key, [82:76] value_length,
    // [146:83] value_word, [151:147] zero
    output logic [151:0]        m_axis_tdata,
    output logic                m_axis_tuser,   // kind
    output logic                m_axis_tlast    // last
);

    localparam int CNT_W   = $clog2(MAX_VALUE + 1);
    localparam int NW_W    = CNT_W - 3;
    localparam int WORDS   = (MAX_VALUE + 7) / 8;
    localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HDR   = 4'b0010,
        S_FETCH = 4'b0100,
        S_WORD  = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [LIMIT_W-1:0]         limit_reg;
    logic [1:0]                 field_reg, field_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [WORD_W-1:0]          asm_reg, asm_next;
    logic [WORD_W-1:0]          tail_reg, tail_next;
    logic                       tail_valid_reg, tail_valid_next;
    logic [NW_W-1:0]            n_full_reg, n_full_next;
    logic [NW_W-1:0]            rd_word_reg, rd_word_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg, out_kind_next;
    logic [STAMP_W-1:0]         out_stamp_reg, out_stamp_next;
    logic [KEY_W-1:0]           out_key_reg, out_key_next;
    logic [LEN_W-1:0]           out_len_reg, out_len_next;
    logic [WORD_W-1:0]          out_word_reg, out_word_next;
    logic                       out_last_reg, out_last_next;

    logic                       in_xfer, out_xfer;
    logic                       is_semi, is_nl, text_byte;
    logic                       clear_rec, store_ok, val_feed;
    logic [2:0]                 lane;
    logic [WORD_W-1:0]          asm_merged;
    num_ctl_t                   stamp_ctl, key_ctl;
    logic signed [STAMP_W-1:0]  stamp_val;
    logic signed [KEY_W-1:0]    key_val;
    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [WORD_W-1:0]          ram_rdata;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = out_valid_reg && m_axis_tready;

    // Byte classification and routing
    assign is_semi   = (s_axis_tdata == CH_SEMI);
    assign is_nl     = (s_axis_tdata == CH_NL);
    assign text_byte = in_xfer && !is_semi && !is_nl;
    assign clear_rec = in_xfer && (is_nl || s_axis_tlast);
    assign store_ok  = (CMP_W'(count_reg) < CMP_W'(limit_reg)) &&
                       (count_reg < CNT_W'(MAX_VALUE));
    assign val_feed  = text_byte && (field_reg == 2'd2) && store_ok;
    assign lane      = count_reg[2:0];

    assign stamp_ctl = '{clear: clear_rec, feed: text_byte && (field_reg == 2'd0),
                         ch: s_axis_tdata};
    assign key_ctl   = '{clear: clear_rec, feed: text_byte && (field_reg == 2'd1),
                         ch: s_axis_tdata};

    drp_num #(
        .WIDTH     (STAMP_W),
        .MAX_CHARS (STAMP_CHARS)
    ) u_stamp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stamp_ctl),
        .value (stamp_val)
    );

    drp_num #(
        .WIDTH     (KEY_W),
        .MAX_CHARS (KEY_CHARS)
    ) u_key (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (key_ctl),
        .value (key_val)
    );

    // Value word assembly; a full word goes to the RAM
    assign asm_merged = asm_reg | (WORD_W'(s_axis_tdata) << {lane, 3'b000});
    assign ram_we     = val_feed && (lane == 3'd7);
    assign ram_waddr  = AW'(count_reg >> 3);

    drp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (asm_merged),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Record state
    always_comb
    begin
        field_next      = field_reg;
        count_next      = count_reg;
        asm_next        = asm_reg;
        tail_next       = tail_reg;
        tail_valid_next = tail_valid_reg;
        n_full_next     = n_full_reg;
        if (in_xfer && is_semi && (field_reg != 2'd3))
        begin
            field_next = field_reg + 2'd1;
        end
        if (val_feed)
        begin
            count_next = count_reg + CNT_W'(1);
            asm_next   = (lane == 3'd7) ? '0 : asm_merged;
        end
        if (in_xfer && is_nl)
        begin
            tail_next       = asm_reg;
            tail_valid_next = (lane != 3'd0);
            n_full_next     = count_reg[CNT_W-1:3];
        end
        if (clear_rec)
        begin
            field_next = 2'd0;
            count_next = '0;
            asm_next   = '0;
        end
    end

    // Drain sequencer
    always_comb
    begin
        state_next     = state_reg;
        rd_word_next   = rd_word_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_stamp_next = out_stamp_reg;
        out_key_next   = out_key_reg;
        out_len_next   = out_len_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        ram_re         = 1'b0;
        ram_raddr      = AW'(rd_word_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && is_nl)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_HEADER;
                    out_stamp_next = stamp_val;
                    out_key_next   = key_val;
                    out_len_next   = LEN_W'(count_reg);
                    out_word_next  = '0;
                    out_last_next  = (count_reg == '0);
                    rd_word_next   = '0;
                    state_next     = S_HDR;
                end
            end
            S_HDR, S_WORD:
            begin
                if (out_xfer)
                begin
                    if (out_last_reg)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else if (rd_word_reg < n_full_reg)
                    begin
                        ram_re         = 1'b1;
                        out_valid_next = 1'b0;
                        state_next     = S_FETCH;
                    end
                    else
                    begin
                        // partial final word
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_WORD;
                        out_stamp_next = '0;
                        out_key_next   = '0;
                        out_len_next   = '0;
                        out_word_next  = tail_reg;
                        out_last_next  = 1'b1;
                        state_next     = S_WORD;
                    end
                end
            end
            S_FETCH:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_WORD;
                out_stamp_next = '0;
                out_key_next   = '0;
                out_len_next   = '0;
                out_word_next  = ram_rdata;
                out_last_next  = ((rd_word_reg + NW_W'(1)) == n_full_reg) && !tail_valid_reg;
                rd_word_next   = rd_word_reg + NW_W'(1);
                state_next     = S_WORD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_reg      <= LIMIT_W'(64);
            field_reg      <= 2'd0;
            count_reg      <= '0;
            asm_reg        <= '0;
            rd_word_reg    <= '0;
            n_full_reg     <= '0;
            tail_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (value_limit_wr)
            begin
                limit_reg <= value_limit_data;
            end
            field_reg      <= field_next;
            count_reg      <= count_next;
            asm_reg        <= asm_next;
            rd_word_reg    <= rd_word_next;
            n_full_reg     <= n_full_next;
            tail_valid_reg <= tail_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tail_reg      <= tail_next;
        out_kind_reg  <= out_kind_next;
        out_stamp_reg <= out_stamp_next;
        out_key_reg   <= out_key_next;
        out_len_reg   <= out_len_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b00000, out_word_reg, out_len_reg, out_key_reg, out_stamp_reg};

`ifndef NO_ASSERTIONS
    // RAM is written only while parsing, never during a drain
    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> (state_reg == S_IDLE))
        else $error("value RAM written during drain");

    // The header is presented whenever the sequencer sits in its header state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HDR) |-> (m_axis_tvalid && (m_axis_tuser == KIND_HEADER)))
        else $error("header state without header on output");

    // Word reads never run past the full words of the record
    assert property (@(posedge clk) disable iff (!rst_n) rd_word_reg <= n_full_reg)
        else $error("drain read past stored words");

    // Buffer fill never exceeds its capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(MAX_VALUE))
        else $error("value count beyond buffer size");
`endif

endmodule

`default_nettype wire

/* src/drp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module drp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/drp_num.sv */
// Decimal field parser with atoi rules: white space, optional sign, digits.
// Depends on drp_pkg.
`default_nettype none

module drp_num
    import drp_pkg::*;
#(
    parameter int WIDTH     = 55,
    parameter int MAX_CHARS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire num_ctl_t                ctl,
    output logic signed [WIDTH-1:0]      value
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   chars_reg, chars_next;
    logic               neg_reg, neg_next;
    logic [WIDTH-1:0]   acc_reg, acc_next;

    logic               is_digit;
    logic               is_ws;
    logic [WIDTH-1:0]   digit_val;
    logic [WIDTH-1:0]   acc_x10;

    assign is_digit  = (ctl.ch >= CH_ZERO) && (ctl.ch <= CH_NINE);
    assign is_ws     = (ctl.ch == CH_SPACE) || (ctl.ch == CH_TAB) || (ctl.ch == CH_VT) ||
                       (ctl.ch == CH_FF) || (ctl.ch == CH_CR);
    assign digit_val = WIDTH'(ctl.ch - CH_ZERO);
    // acc * 10 wraps at the field width
    assign acc_x10   = (acc_reg << 3) + (acc_reg << 1);

    // Character step
    always_comb
    begin
        phase_next = phase_reg;
        chars_next = chars_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (ctl.clear)
        begin
            phase_next = PH_SPACE;
            chars_next = '0;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
        else if (ctl.feed && (chars_reg < CNT_W'(MAX_CHARS)))
        begin
            chars_next = chars_reg + CNT_W'(1);
            case (phase_reg)
                PH_SPACE:
                begin
                    if (is_ws)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if ((ctl.ch == CH_PLUS) || (ctl.ch == CH_MINUS))
                    begin
                        neg_next   = (ctl.ch == CH_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = digit_val;
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGIT:
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_x10 + digit_val;
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            chars_reg <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            chars_reg <= chars_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // Apply the sign
    assign value = neg_reg ? $signed(-acc_reg) : $signed(acc_reg);

endmodule

`default_nettype wire
